/* rtl/cdn_pkg.sv */
// Package for the calendar date and time normalizer.
// Holds the field widths, time and calendar constants and the month-length function.
// It has no dependencies of its own.
package cdn_pkg;

  // Widths of the input fields.
  localparam int unsigned RawDayW    = 12;
  localparam int unsigned RawMonthW  = 4;
  localparam int unsigned RawYearW   = 14;
  localparam int unsigned RawTimeW   = 8;

  // Widths of the output fields.
  localparam int unsigned NormDayW   = 5;
  localparam int unsigned NormHourW  = 5;
  localparam int unsigned NormMinSecW = 6;

  // Width of the shared subtractor operands.
  localparam int unsigned AluW = 14;

  // Time and calendar constants.
  localparam logic [AluW-1:0] SecPerMin   = AluW'(60);
  localparam logic [AluW-1:0] HourPerDay  = AluW'(24);
  localparam logic [AluW-1:0] YearsPerEra = AluW'(400);
  localparam logic [8:0]      EraLast     = 9'd399;
  localparam logic [8:0]      Century1    = 9'd100;
  localparam logic [8:0]      Century2    = 9'd200;
  localparam logic [8:0]      Century3    = 9'd300;
  localparam logic [RawMonthW-1:0] MonthFirst = 4'd1;
  localparam logic [RawMonthW-1:0] MonthLast  = 4'd12;
  localparam logic [RawMonthW-1:0] MonthFeb   = 4'd2;

  // Shift of the largest multiple of 400 tried when reducing the year.
  localparam logic [2:0] EraShiftMax = 3'd5;

  // Days in a month; an invalid month number has length zero.
  function automatic logic [4:0] month_length(input logic [RawMonthW-1:0] mon,
                                              input logic leap);
    logic [4:0] len;
    len = 5'd0;
    case (mon) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MonthFeb:                                   len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

/* rtl/calendar_datetime_normalizer_unit.sv */
// Top level of the calendar date and time normalizer.
// Uses cdn_pkg for widths, constants and the month-length function.
// One shared subtractor under a small sequencer does all of the subtractions.

// Normalizes one date and time per transfer. Seconds, minutes and hours are
// reduced by repeated subtraction of 60, 60 and 24, each step carrying one into
// the next field, and each stage is left on the first subtraction that would
// borrow. The year is then reduced modulo 400 by a six-step restoring division
// for the leap rule, and the days are used up one month per cycle until they
// fit in the current month. The result then waits in the done state until the
// output register is free, and is loaded there. The single subtractor is used
// once per cycle. The input side takes no new transfer until the current
// result has been loaded into the output register, so one item is in work
// at a time.
module calendar_datetime_normalizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata, from bit 0 up: raw_day[11:0], raw_month[15:12],
  // raw_year[29:16], raw_hour[37:30], raw_minute[45:38], raw_second[53:46], zeros.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  // Output stream. tdata, from bit 0 up: norm_day[4:0], norm_month[8:5],
  // norm_year[22:9], norm_hour[27:23], norm_minute[33:28], norm_second[39:34].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata
);

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSec  = 3'd1;
  localparam logic [2:0] StMin  = 3'd2;
  localparam logic [2:0] StHour = 3'd3;
  localparam logic [2:0] StYmod = 3'd4;
  localparam logic [2:0] StMon  = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [2:0]  shift_q;
  logic [12:0] day_q;
  logic [3:0]  mon_q;
  logic [14:0] year_q;
  logic [13:0] rem_q;
  logic [8:0]  hour_q;
  logic [8:0]  min_q;
  logic [7:0]  sec_q;
  logic        out_valid_q;
  logic [39:0] out_data_q;

  logic [cdn_pkg::AluW-1:0] alu_a, alu_b;
  logic [cdn_pkg::AluW:0]   alu_diff;
  logic                     alu_ge;
  logic                     leap;
  logic [4:0]               mon_len;
  logic                     in_xfer;
  logic                     out_free;
  logic                     load_out;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign load_out = (state_q == StDone) && out_free;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Leap year from the low year bits and the year modulo 400.
  assign leap = (year_q[1:0] == 2'b00) &&
                !((rem_q[8:0] == cdn_pkg::Century1) || (rem_q[8:0] == cdn_pkg::Century2) ||
                  (rem_q[8:0] == cdn_pkg::Century3));
  assign mon_len = cdn_pkg::month_length(mon_q, leap);

  // Operand selection for the shared subtractor.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      StSec: begin
        alu_a = cdn_pkg::AluW'(sec_q);
        alu_b = cdn_pkg::SecPerMin;
      end
      StMin: begin
        alu_a = cdn_pkg::AluW'(min_q);
        alu_b = cdn_pkg::SecPerMin;
      end
      StHour: begin
        alu_a = cdn_pkg::AluW'(hour_q);
        alu_b = cdn_pkg::HourPerDay;
      end
      StYmod: begin
        alu_a = rem_q;
        alu_b = cdn_pkg::YearsPerEra << shift_q;
      end
      StMon: begin
        alu_a = cdn_pkg::AluW'(day_q);
        alu_b = cdn_pkg::AluW'(mon_len);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // The shared subtractor and its no-borrow flag.
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[cdn_pkg::AluW];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_xfer) state_d = StSec;
      StSec:  if (!alu_ge) state_d = StMin;
      StMin:  if (!alu_ge) state_d = StHour;
      StHour: if (!alu_ge) state_d = StYmod;
      StYmod: if (shift_q == 3'd0) state_d = StMon;
      StMon: begin
        // Stop once the remaining days fit in the current month.
        if (!alu_ge || (alu_diff == '0)) state_d = StDone;
      end
      StDone: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: each state updates the fields it works on.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          day_q   <= {1'b0, s_axis_tdata[11:0]};
          mon_q   <= s_axis_tdata[15:12];
          year_q  <= {1'b0, s_axis_tdata[29:16]};
          rem_q   <= s_axis_tdata[29:16];
          hour_q  <= {1'b0, s_axis_tdata[37:30]};
          min_q   <= {1'b0, s_axis_tdata[45:38]};
          sec_q   <= s_axis_tdata[53:46];
          shift_q <= cdn_pkg::EraShiftMax;
        end
      end
      StSec: begin
        if (alu_ge) begin
          sec_q <= alu_diff[7:0];
          min_q <= min_q + 9'd1;
        end
      end
      StMin: begin
        if (alu_ge) begin
          min_q  <= alu_diff[8:0];
          hour_q <= hour_q + 9'd1;
        end
      end
      StHour: begin
        if (alu_ge) begin
          hour_q <= alu_diff[8:0];
          day_q  <= day_q + 13'd1;
        end
      end
      StYmod: begin
        // Restoring division by 400, largest multiple first.
        if (alu_ge) rem_q <= alu_diff[cdn_pkg::AluW-1:0];
        if (shift_q != 3'd0) shift_q <= shift_q - 3'd1;
      end
      StMon: begin
        // Use up one month of days and step to the next month.
        if (alu_ge && (alu_diff != '0)) begin
          day_q <= alu_diff[12:0];
          if (mon_q >= cdn_pkg::MonthLast) begin
            mon_q  <= cdn_pkg::MonthFirst;
            year_q <= year_q + 15'd1;
            rem_q  <= (rem_q[8:0] == cdn_pkg::EraLast) ? '0 : rem_q + 14'd1;
          end else begin
            mon_q <= mon_q + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded once the result is complete.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {sec_q[5:0], min_q[5:0], hour_q[4:0], year_q[13:0], mon_q, day_q[4:0]};
    end
  end

`ifndef SYNTHESIS
  // Time fields are reduced before any result is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[27:23] < 5'd24) && (m_axis_tdata[33:28] < 6'd60) &&
                      (m_axis_tdata[39:34] < 6'd60))
    else $error("output time fields out of range");

  // The year remainder stays below 400 while months are stepped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMon) |-> (rem_q < 14'd400))
    else $error("year remainder out of range");

  // A finished result has a day of at most 31.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> (day_q <= 13'd31))
    else $error("day not reduced to month length");
`endif

endmodule
